// File: sv/dda_pkg.sv
// shared types, constants and state encoding for the dda line rasterizer
package dda_pkg;

    // width of one signed grid coordinate
    localparam int COORD_W = 6;

    // default grid half extents
    localparam int HALF_WIDTH_DEF  = 32;
    localparam int HALF_HEIGHT_DEF = 24;

    typedef logic signed [COORD_W-1:0] coord_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } dda_state_t;

endpackage

// File: sv/dda_seg_if.sv
// valid/ready channel carrying one line segment item
interface dda_seg_if;
    logic            valid;
    logic            ready;
    dda_pkg::coord_t start_x;
    dda_pkg::coord_t start_y;
    dda_pkg::coord_t end_x;
    dda_pkg::coord_t end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

// File: sv/dda_pix_if.sv
// valid/ready channel carrying one plotted pixel item
interface dda_pix_if;
    logic            valid;
    logic            ready;
    dda_pkg::coord_t pixel_x;
    dda_pkg::coord_t pixel_y;
    logic            last_pixel;

    modport source (output valid, output pixel_x, output pixel_y,
                    output last_pixel, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y,
                    input last_pixel, output ready);
endinterface

// File: sv/dda_line_rasterizer.sv
// top level of the dda line rasterizer: segment in, pixel stream out
//
// A segment item is taken only while the block is idle. Its endpoints are
// clamped to the grid, then the setup state forms dx, dy and
// steps = max(|dx|, |dy|). After that the block shows one pixel per cycle
// while the sink takes them, steps+1 pixels in all, the final one flagged
// with last_pixel. The next segment is accepted in the cycle after the
// last pixel leaves. Each axis is tracked as quotient and remainder of
// start*steps + i*d over steps by one small add/compare step per pixel,
// so every point is the exact rounded value, halves away from zero,
// with no divider and no drift.
module dda_line_rasterizer #(
    parameter int HALF_WIDTH  = dda_pkg::HALF_WIDTH_DEF,
    parameter int HALF_HEIGHT = dda_pkg::HALF_HEIGHT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    dda_seg_if.sink       seg_in,
    dda_pix_if.source     pix_out
);

    localparam int CW = dda_pkg::COORD_W;

    // saturate a coordinate to [lo, hi]
    function automatic dda_pkg::coord_t clamp_coord(input dda_pkg::coord_t v,
                                                    input int lo, input int hi);
        int vi;
        vi = int'(v);
        if (vi < lo)
            vi = lo;
        else if (vi > hi)
            vi = hi;
        return dda_pkg::coord_t'(vi);
    endfunction

    // state registers
    dda_pkg::dda_state_t state_reg, state_next;

    dda_pkg::coord_t     x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [CW:0]  dx_reg, dy_reg;
    logic [CW-1:0]       steps_reg, steps_next;
    logic [CW-1:0]       idx_reg;
    logic signed [CW:0]  qx_reg, qx_next, qy_reg, qy_next;
    logic [CW-1:0]       rx_reg, rx_next, ry_reg, ry_next;

    logic seg_acc;
    logic pix_acc;
    logic is_last;

    logic signed [CW:0]   dx_c, dy_c;
    logic [CW-1:0]        adx_c, ady_c;
    logic signed [CW+1:0] sx_c, sy_c;
    logic                 rnd_x, rnd_y;
    logic signed [CW:0]   px_c, py_c;

    assign seg_acc = seg_in.valid && seg_in.ready;
    assign pix_acc = pix_out.valid && pix_out.ready;
    assign is_last = (idx_reg == steps_reg);

    // setup arithmetic: deltas and step count
    always_comb
    begin
        dx_c  = {x2_reg[CW-1], x2_reg} - {x1_reg[CW-1], x1_reg};
        dy_c  = {y2_reg[CW-1], y2_reg} - {y1_reg[CW-1], y1_reg};
        adx_c = dx_c[CW] ? CW'(-dx_c) : dx_c[CW-1:0];
        ady_c = dy_c[CW] ? CW'(-dy_c) : dy_c[CW-1:0];
        steps_next = (adx_c > ady_c) ? adx_c : ady_c;
    end

    // per-pixel advance of quotient and remainder for both axes
    always_comb
    begin
        sx_c = $signed({2'b00, rx_reg}) + {dx_reg[CW], dx_reg};
        sy_c = $signed({2'b00, ry_reg}) + {dy_reg[CW], dy_reg};
        qx_next = qx_reg;
        qy_next = qy_reg;
        if (sx_c >= $signed({2'b00, steps_reg}))
        begin
            rx_next = CW'(sx_c - $signed({2'b00, steps_reg}));
            qx_next = qx_reg + $signed({{CW{1'b0}}, 1'b1});
        end
        else if (sx_c < 0)
        begin
            rx_next = CW'(sx_c + $signed({2'b00, steps_reg}));
            qx_next = qx_reg - $signed({{CW{1'b0}}, 1'b1});
        end
        else
        begin
            rx_next = sx_c[CW-1:0];
        end
        if (sy_c >= $signed({2'b00, steps_reg}))
        begin
            ry_next = CW'(sy_c - $signed({2'b00, steps_reg}));
            qy_next = qy_reg + $signed({{CW{1'b0}}, 1'b1});
        end
        else if (sy_c < 0)
        begin
            ry_next = CW'(sy_c + $signed({2'b00, steps_reg}));
            qy_next = qy_reg - $signed({{CW{1'b0}}, 1'b1});
        end
        else
        begin
            ry_next = sy_c[CW-1:0];
        end
    end

    // rounding: non-negative values round up at half, negative past half
    always_comb
    begin
        if (steps_reg == '0)
        begin
            rnd_x = 1'b0;
            rnd_y = 1'b0;
        end
        else if (qx_reg[CW])
        begin
            rnd_x = ({rx_reg, 1'b0} > {1'b0, steps_reg});
            rnd_y = qy_reg[CW] ? ({ry_reg, 1'b0} > {1'b0, steps_reg})
                               : ({ry_reg, 1'b0} >= {1'b0, steps_reg});
        end
        else
        begin
            rnd_x = ({rx_reg, 1'b0} >= {1'b0, steps_reg});
            rnd_y = qy_reg[CW] ? ({ry_reg, 1'b0} > {1'b0, steps_reg})
                               : ({ry_reg, 1'b0} >= {1'b0, steps_reg});
        end
        px_c = qx_reg + $signed({{CW{1'b0}}, rnd_x});
        py_c = qy_reg + $signed({{CW{1'b0}}, rnd_y});
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dda_pkg::ST_IDLE:
                if (seg_acc)
                    state_next = dda_pkg::ST_SETUP;
            dda_pkg::ST_SETUP:
                state_next = dda_pkg::ST_RUN;
            dda_pkg::ST_RUN:
                if (pix_acc && is_last)
                    state_next = dda_pkg::ST_IDLE;
            default:
                state_next = dda_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        seg_in.ready  = 1'b0;
        pix_out.valid = 1'b0;
        case (state_reg)
            dda_pkg::ST_IDLE:  seg_in.ready  = 1'b1;
            dda_pkg::ST_SETUP: seg_in.ready  = 1'b0;
            dda_pkg::ST_RUN:   pix_out.valid = 1'b1;
            default:           seg_in.ready  = 1'b0;
        endcase
    end

    // pixel payload
    assign pix_out.pixel_x    = px_c[CW-1:0];
    assign pix_out.pixel_y    = py_c[CW-1:0];
    assign pix_out.last_pixel = is_last;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dda_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == dda_pkg::ST_SETUP)
                idx_reg <= '0;
            else if (pix_acc && !is_last)
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (seg_acc)
        begin
            x1_reg <= clamp_coord(seg_in.start_x, -HALF_WIDTH, HALF_WIDTH - 1);
            y1_reg <= clamp_coord(seg_in.start_y, -HALF_HEIGHT, HALF_HEIGHT - 1);
            x2_reg <= clamp_coord(seg_in.end_x, -HALF_WIDTH, HALF_WIDTH - 1);
            y2_reg <= clamp_coord(seg_in.end_y, -HALF_HEIGHT, HALF_HEIGHT - 1);
        end
        if (state_reg == dda_pkg::ST_SETUP)
        begin
            dx_reg    <= dx_c;
            dy_reg    <= dy_c;
            steps_reg <= steps_next;
            qx_reg    <= {x1_reg[CW-1], x1_reg};
            qy_reg    <= {y1_reg[CW-1], y1_reg};
            rx_reg    <= '0;
            ry_reg    <= '0;
        end
        else if (pix_acc && !is_last)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
    end

    // the block never takes a segment while pixels are pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(seg_in.ready && pix_out.valid))
        else $error("segment ready while pixels pending");

    // the final pixel returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_acc && pix_out.last_pixel) |=> seg_in.ready)
        else $error("not idle after final pixel");

    // the step counter never passes the step total while running
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> (idx_reg <= steps_reg))
        else $error("step index past step total");

    // remainders stay below the step total on nonzero segments
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_out.valid && steps_reg != '0) |-> (rx_reg < steps_reg && ry_reg < steps_reg))
        else $error("remainder out of range");

endmodule

// File: tb/dda_line_rasterizer_tb.sv
// self-checking testbench for the dda line rasterizer: segments in, checked pixel stream out
`timescale 1ns / 1ps

module dda_line_rasterizer_tb;

    localparam int GRID_HALF_W   = dda_pkg::HALF_WIDTH_DEF;
    localparam int GRID_HALF_H   = dda_pkg::HALF_HEIGHT_DEF;
    localparam int SEGMENT_SLACK = 80;
    localparam int HOLD_CYCLES   = 300;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_ITEMS  = 355;

    typedef struct packed {
        dda_pkg::coord_t pixel_x;
        dda_pkg::coord_t pixel_y;
        logic            last_pixel;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;

    dda_seg_if seg_if ();
    dda_pix_if pix_if ();

    // pixels still owed by the block, oldest first
    pixel_t pixel_queue[$];

    int unsigned error_count   = 0;
    int unsigned segment_count = 0;
    int unsigned pixel_count   = 0;
    int unsigned zero_count    = 0;
    int unsigned clamp_count   = 0;
    int unsigned longest_steps = 0;
    int unsigned burst_left    = 0;
    int unsigned hold_left     = 0;
    logic        hold_request  = 1'b0;

    dda_line_rasterizer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .seg_in  (seg_if),
        .pix_out (pix_if)
    );

    always #5 clk = ~clk;

    // saturate one endpoint coordinate onto the grid
    function automatic int clamp_coord(dda_pkg::coord_t v, int half);
        int c;
        c = int'(v);
        if (c < -half)
            c = -half;
        else if (c > half - 1)
            c = half - 1;
        return c;
    endfunction

    // num/den rounded half away from zero, den positive
    function automatic int round_ratio(int num, int den);
        if (num >= 0)
            return (2 * num + den) / (2 * den);
        return -((-2 * num + den) / (2 * den));
    endfunction

    // queue every pixel that one segment should produce
    function automatic void plot_segment(dda_pkg::coord_t sx, dda_pkg::coord_t sy,
                                         dda_pkg::coord_t ex, dda_pkg::coord_t ey);
        int x1, y1, x2, y2;
        int dx, dy, adx, ady, steps;
        pixel_t p;
        x1 = clamp_coord(sx, GRID_HALF_W);
        y1 = clamp_coord(sy, GRID_HALF_H);
        x2 = clamp_coord(ex, GRID_HALF_W);
        y2 = clamp_coord(ey, GRID_HALF_H);
        if (x1 != int'(sx) || y1 != int'(sy) || x2 != int'(ex) || y2 != int'(ey))
            clamp_count++;
        dx    = x2 - x1;
        dy    = y2 - y1;
        adx   = (dx < 0) ? -dx : dx;
        ady   = (dy < 0) ? -dy : dy;
        steps = (adx > ady) ? adx : ady;
        if (steps == 0)
            zero_count++;
        if (steps > longest_steps)
            longest_steps = steps;
        for (int i = 0; i <= steps; i++)
        begin
            if (steps == 0)
            begin
                p.pixel_x = dda_pkg::coord_t'(x1);
                p.pixel_y = dda_pkg::coord_t'(y1);
            end
            else
            begin
                p.pixel_x = dda_pkg::coord_t'(round_ratio(x1 * steps + i * dx, steps));
                p.pixel_y = dda_pkg::coord_t'(round_ratio(y1 * steps + i * dy, steps));
            end
            p.last_pixel = (i == steps);
            pixel_queue.push_back(p);
        end
    endfunction

    // offer one segment until taken, then maybe close the burst with a gap
    task automatic send_segment(input dda_pkg::coord_t sx, input dda_pkg::coord_t sy,
                                input dda_pkg::coord_t ex, input dda_pkg::coord_t ey);
        seg_if.start_x <= sx;
        seg_if.start_y <= sy;
        seg_if.end_x   <= ex;
        seg_if.end_y   <= ey;
        seg_if.valid   <= 1'b1;
        do
            @(posedge clk);
        while (!seg_if.ready);
        plot_segment(sx, sy, ex, ey);
        segment_count++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(8, 1);
            seg_if.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    // sender stays quiet until every owed pixel has come out
    task automatic wait_for_drain();
        seg_if.valid <= 1'b0;
        @(posedge clk);
        while (pixel_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_zero_length();
        send_segment(0, 0, 0, 0);
        send_segment(-32, -24, -32, -24);
        send_segment(31, 23, 31, 23);
        send_segment(31, 31, 31, 31);
        wait_for_drain();
    endtask

    task automatic test_grid_extremes();
        send_segment(-32, 0, 31, 0);
        send_segment(31, 0, -32, 0);
        send_segment(0, -24, 0, 23);
        send_segment(-32, -24, 31, 23);
        send_segment(31, 23, -32, -24);
        send_segment(-32, 23, 31, -24);
        wait_for_drain();
    endtask

    task automatic test_half_rounding();
        send_segment(0, 0, 2, 1);
        send_segment(0, 0, -2, -1);
        send_segment(-1, -1, 1, 0);
        send_segment(1, 0, -1, -1);
        send_segment(0, 0, 4, 1);
        wait_for_drain();
    endtask

    task automatic test_off_grid_clamp();
        send_segment(0, -32, 0, 31);
        send_segment(-32, 31, 31, -32);
        send_segment(5, 27, 5, -27);
        wait_for_drain();
    endtask

    // receiver holds off for a long stretch while segments keep coming
    task automatic test_output_stall();
        hold_request <= 1'b1;
        @(posedge clk);
        hold_request <= 1'b0;
        send_segment(-32, -24, 31, 20);
        send_segment(31, -10, -30, 10);
        send_segment(0, 23, 0, -24);
        send_segment(-7, 3, 9, -12);
        wait_for_drain();
    endtask

    task automatic test_random_segments(input int unsigned count);
        dda_pkg::coord_t sx, sy, ex, ey;
        int ox, oy;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                // any bit pattern, off-grid rows included
                0, 1:
                begin
                    sx = dda_pkg::coord_t'($urandom);
                    sy = dda_pkg::coord_t'($urandom);
                    ex = dda_pkg::coord_t'($urandom);
                    ey = dda_pkg::coord_t'($urandom);
                end
                // short segments, sometimes degenerate
                2, 3:
                begin
                    ox = int'($urandom_range(56)) - 28;
                    oy = int'($urandom_range(40)) - 20;
                    sx = dda_pkg::coord_t'(ox);
                    sy = dda_pkg::coord_t'(oy);
                    ex = dda_pkg::coord_t'(ox + int'($urandom_range(6)) - 3);
                    ey = dda_pkg::coord_t'(oy + int'($urandom_range(6)) - 3);
                end
                // anywhere on the grid
                default:
                begin
                    sx = dda_pkg::coord_t'(int'($urandom_range(63)) - 32);
                    sy = dda_pkg::coord_t'(int'($urandom_range(47)) - 24);
                    ex = dda_pkg::coord_t'(int'($urandom_range(63)) - 32);
                    ey = dda_pkg::coord_t'(int'($urandom_range(47)) - 24);
                end
            endcase
            send_segment(sx, sy, ex, ey);
            if ($urandom_range(49) == 0)
                wait_for_drain();
        end
        wait_for_drain();
    endtask

    // long hold-off counter for the output stall test
    always @(posedge clk)
    begin
        if (hold_request)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // receiver ready: switches among always-ready, random and rotating-mask modes
    initial
    begin : pixel_receiver
        int unsigned mode;
        int unsigned mode_left;
        logic [7:0] mask;
        pix_if.ready = 1'b0;
        mode      = 0;
        mode_left = 0;
        mask      = 8'b1011_0110;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(3);
                mode_left = $urandom_range(120, 20);
            end
            mode_left--;
            mask = {mask[6:0], mask[7]};
            if (hold_request || hold_left != 0)
                pix_if.ready <= 1'b0;
            else
            begin
                case (mode)
                    0: pix_if.ready <= 1'b1;
                    1: pix_if.ready <= ($urandom_range(3) != 0);
                    2: pix_if.ready <= ($urandom_range(9) < 4);
                    default: pix_if.ready <= mask[0];
                endcase
            end
        end
    end

    // compare each taken pixel with the oldest owed one
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            pixel_count++;
            if (pixel_queue.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected pixel x=%0d y=%0d last=%0b",
                             pix_if.pixel_x, pix_if.pixel_y, pix_if.last_pixel);
            end
            else
            begin
                want = pixel_queue.pop_front();
                if (pix_if.pixel_x !== want.pixel_x || pix_if.pixel_y !== want.pixel_y ||
                    pix_if.last_pixel !== want.last_pixel)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display({"pixel %0d: expected x=%0d y=%0d last=%0b, ",
                                  "got x=%0d y=%0d last=%0b"},
                                 pixel_count, want.pixel_x, want.pixel_y, want.last_pixel,
                                 pix_if.pixel_x, pix_if.pixel_y, pix_if.last_pixel);
                end
            end
        end
    end

    // run limit
    initial
    begin
        #8_000_000;
        $display("timeout with %0d pixels still owed", pixel_queue.size());
        $display("dda_line_rasterizer: mismatch");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        seg_if.valid   = 1'b0;
        seg_if.start_x = '0;
        seg_if.start_y = '0;
        seg_if.end_x   = '0;
        seg_if.end_y   = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_length();
        test_grid_extremes();
        test_half_rounding();
        test_off_grid_clamp();
        test_output_stall();
        test_random_segments(RANDOM_ITEMS);

        repeat (SEGMENT_SLACK) @(posedge clk);
        if (pixel_queue.size() != 0)
        begin
            error_count += pixel_queue.size();
            $display("%0d expected pixels never arrived", pixel_queue.size());
        end

        $display("ran %0d segments, %0d pixels checked, longest line %0d steps",
                 segment_count, pixel_count, longest_steps);
        $display("%0d zero-length segments, %0d with clamped endpoints, %0d errors",
                 zero_count, clamp_count, error_count);
        if (error_count == 0)
            $display("dda_line_rasterizer: match");
        else
            $display("dda_line_rasterizer: mismatch");
        $finish;
    end

endmodule
